// ----- hw/rtl/tabp_pkg.sv -----
// Shared types, codes and constants of the train air brake pressure model.
// No dependencies; every other file of the block imports this package.
package tabp_pkg;

  typedef enum logic [2:0] {
    CMD_APPLY     = 3'd0,
    CMD_NEUTRAL   = 3'd1,
    CMD_RELEASE   = 3'd2,
    CMD_EMERGENCY = 3'd3,
    CMD_SERVICE   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_EMERGENCY = 2'd0,
    MODE_SERVICE   = 2'd1,
    MODE_DRIVER    = 2'd2,
    MODE_KEEP      = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_PIPE_RATE = 3'd0,
    REG_CYL_RATE  = 3'd1,
    REG_SERVICE   = 3'd2,
    REG_RELEASE   = 3'd3,
    REG_DEADBAND  = 3'd4
  } reg_idx_t;

  localparam int CFG_AW = 5;

  localparam logic [13:0] PIPE_RATE_RST = 14'd1000;
  localparam logic [13:0] CYL_RATE_RST  = 14'd2640;
  localparam logic [12:0] SERVICE_RST   = 13'd3500;
  localparam logic [12:0] RELEASE_RST   = 13'd5100;
  localparam logic [9:0]  DEADBAND_RST  = 10'd100;
  localparam logic [12:0] PIPE_RST      = 13'd5100;

  localparam logic [13:0] LOW_SPEED_CMS     = 14'd694;
  localparam logic [13:0] HIGH_SPEED_CMS    = 14'd5970;
  localparam logic [12:0] FULL_APPLY_MBAR   = 13'd4500;
  localparam logic [12:0] FULL_RELEASE_MBAR = 13'd5100;
  localparam logic [11:0] CAP_LOW_MBAR      = 12'd3800;
  localparam logic [11:0] CAP_HIGH_MBAR     = 12'd2600;
  localparam logic [11:0] LEVER_MBAR_PER_PCT = 12'd38;

  typedef struct packed {
    logic [13:0] pipe_rate;
    logic [13:0] cyl_rate;
    logic [12:0] service_target;
    logic [12:0] release_limit;
    logic [9:0]  deadband;
  } cfg_t;

  typedef struct packed {
    logic [9:0]        ms;
    logic [13:0]       speed;
    logic signed [7:0] lever;
    mode_t             mode;
    logic              emerg;
    logic              apply;
    logic              rel;
  } tick_t;

  typedef struct packed {
    logic [13:0]       speed;
    logic signed [7:0] lever;
    mode_t             mode;
    logic              emerg;
    logic              apply;
    logic              rel;
    logic [13:0]       pstep;
    logic [13:0]       cstep;
  } step_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [12:0]       pipe;
    logic [13:0]       speed;
    logic signed [7:0] lever;
    logic [13:0]       cstep;
  } pipe_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [12:0] pipe;
    logic [13:0] cstep;
    logic [11:0] tgt_trailer;
    logic [11:0] tgt_loco;
    logic [11:0] tgt_lever;
  } tgt_t;

  typedef struct packed {
    logic [11:0] shown;
    logic [11:0] lever_cyl;
    logic [11:0] loco_cyl;
    logic [11:0] trailer_cyl;
    logic [12:0] pipe;
    cmd_t        cmd;
  } res_t;

endpackage

// ----- hw/rtl/tabp_cfg.sv -----
// Configuration register file behind the APB-style port.
// Depends on tabp_pkg for register indexes, reset values and cfg_t.
module tabp_cfg
  import tabp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pipe_rate      <= PIPE_RATE_RST;
      cfg_r.cyl_rate       <= CYL_RATE_RST;
      cfg_r.service_target <= SERVICE_RST;
      cfg_r.release_limit  <= RELEASE_RST;
      cfg_r.deadband       <= DEADBAND_RST;
    end else if (wr_en) begin
      case (idx)
        REG_PIPE_RATE: cfg_r.pipe_rate      <= pwdata[13:0];
        REG_CYL_RATE:  cfg_r.cyl_rate       <= pwdata[13:0];
        REG_SERVICE:   cfg_r.service_target <= pwdata[12:0];
        REG_RELEASE:   cfg_r.release_limit  <= pwdata[12:0];
        REG_DEADBAND:  cfg_r.deadband       <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PIPE_RATE: prdata = {18'd0, cfg_r.pipe_rate};
      REG_CYL_RATE:  prdata = {18'd0, cfg_r.cyl_rate};
      REG_SERVICE:   prdata = {19'd0, cfg_r.service_target};
      REG_RELEASE:   prdata = {19'd0, cfg_r.release_limit};
      REG_DEADBAND:  prdata = {22'd0, cfg_r.deadband};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// ----- hw/rtl/tabp_rate.sv -----
// Input register and the pressure step per tick: rate times elapsed time,
// then divided by 1000 through a reciprocal multiply. Depends on tabp_pkg.
module tabp_rate
  import tabp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  tick_t in_tick,
  output logic  out_valid,
  input  logic  out_ready,
  output step_t out_step
);

  localparam logic [24:0] RECIP_1000 = 25'd17179870;
  localparam int          RECIP_SH   = 34;

  logic        s1_vld_r;
  tick_t       s1_tick_r;
  logic        s2_vld_r;
  tick_t       s2_tick_r;
  logic [23:0] s2_pprod_r;
  logic [23:0] s2_cprod_r;
  logic        s3_vld_r;
  step_t       s3_step_r;

  logic        rdy1;
  logic        rdy2;
  logic        rdy3;
  logic [23:0] pprod_nxt;
  logic [23:0] cprod_nxt;
  logic [48:0] pquot;
  logic [48:0] cquot;

  assign rdy3     = !s3_vld_r || out_ready;
  assign rdy2     = !s2_vld_r || rdy3;
  assign rdy1     = !s1_vld_r || rdy2;
  assign in_ready = rdy1;

  assign pprod_nxt = {10'd0, cfg.pipe_rate} * {14'd0, s1_tick_r.ms};
  assign cprod_nxt = {10'd0, cfg.cyl_rate} * {14'd0, s1_tick_r.ms};
  assign pquot     = {25'd0, s2_pprod_r} * {24'd0, RECIP_1000};
  assign cquot     = {25'd0, s2_cprod_r} * {24'd0, RECIP_1000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (rdy1) s1_vld_r <= in_valid;
      if (rdy2) s2_vld_r <= s1_vld_r;
      if (rdy3) s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_tick_r <= in_tick;
    end
    if (rdy2 && s1_vld_r) begin
      s2_tick_r  <= s1_tick_r;
      s2_pprod_r <= pprod_nxt;
      s2_cprod_r <= cprod_nxt;
    end
    if (rdy3 && s2_vld_r) begin
      s3_step_r.speed <= s2_tick_r.speed;
      s3_step_r.lever <= s2_tick_r.lever;
      s3_step_r.mode  <= s2_tick_r.mode;
      s3_step_r.emerg <= s2_tick_r.emerg;
      s3_step_r.apply <= s2_tick_r.apply;
      s3_step_r.rel   <= s2_tick_r.rel;
      s3_step_r.pstep <= pquot[RECIP_SH+13:RECIP_SH];
      s3_step_r.cstep <= cquot[RECIP_SH+13:RECIP_SH];
    end
  end

  assign out_valid = s3_vld_r;
  assign out_step  = s3_step_r;

endmodule

// ----- hw/rtl/tabp_pipe.sv -----
// Brake command selection and brake pipe ramp; holds the command and pipe
// pressure state. Depends on tabp_pkg.
module tabp_pipe
  import tabp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  step_t in_step,
  output logic  out_valid,
  input  logic  out_ready,
  output pipe_t out_pipe
);

  cmd_t        cmd_r;
  cmd_t        cmd_sel;
  cmd_t        cmd_nxt;
  logic [12:0] pipe_r;
  logic [12:0] pipe_nxt;
  logic [13:0] pipe_x;
  logic [12:0] svc;
  logic [12:0] lim;
  logic [13:0] step;
  logic        vld_r;
  pipe_t       res_r;
  logic        load;

  assign in_ready = !vld_r || out_ready;
  assign load     = in_valid && in_ready;
  assign pipe_x   = {1'b0, pipe_r};
  assign svc      = cfg.service_target;
  assign lim      = cfg.release_limit;
  assign step     = in_step.pstep;

  always_comb begin
    cmd_sel = cmd_r;
    unique case (in_step.mode)
      MODE_DRIVER: begin
        if (in_step.emerg) begin
          cmd_sel = CMD_EMERGENCY;
        end else if (in_step.rel && !in_step.apply) begin
          cmd_sel = CMD_RELEASE;
        end else if (in_step.apply && !in_step.rel) begin
          cmd_sel = CMD_APPLY;
        end else if (!in_step.apply && !in_step.rel) begin
          cmd_sel = CMD_NEUTRAL;
        end
      end
      MODE_EMERGENCY: cmd_sel = CMD_EMERGENCY;
      MODE_SERVICE:   cmd_sel = CMD_SERVICE;
      MODE_KEEP:      cmd_sel = cmd_r;
    endcase

    cmd_nxt  = cmd_sel;
    pipe_nxt = pipe_r;
    priority if (cmd_r == CMD_EMERGENCY && cmd_sel == CMD_EMERGENCY && pipe_r != 13'd0) begin
      pipe_nxt = (pipe_x > step) ? 13'(pipe_x - step) : 13'd0;
    end else if (cmd_r == CMD_SERVICE && pipe_r > svc) begin
      cmd_nxt  = CMD_SERVICE;
      pipe_nxt = ({1'b0, pipe_r - svc} > step) ? 13'(pipe_x - step) : svc;
    end else if (cmd_r == CMD_SERVICE && pipe_r < svc) begin
      cmd_nxt  = CMD_SERVICE;
      pipe_nxt = ({1'b0, svc - pipe_r} > step) ? 13'(pipe_x + step) : svc;
    end else if (cmd_sel == CMD_RELEASE) begin
      if (pipe_r >= lim) begin
        pipe_nxt = lim;
      end else begin
        pipe_nxt = ({1'b0, lim - pipe_r} > step) ? 13'(pipe_x + step) : lim;
      end
    end else if (cmd_sel == CMD_APPLY) begin
      pipe_nxt = (pipe_x > step) ? 13'(pipe_x - step) : 13'd0;
    end else begin
      pipe_nxt = pipe_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r  <= CMD_NEUTRAL;
      pipe_r <= PIPE_RST;
      vld_r  <= 1'b0;
    end else begin
      if (in_ready) vld_r <= in_valid;
      if (load) begin
        cmd_r  <= cmd_nxt;
        pipe_r <= pipe_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r.cmd   <= cmd_nxt;
      res_r.pipe  <= pipe_nxt;
      res_r.speed <= in_step.speed;
      res_r.lever <= in_step.lever;
      res_r.cstep <= in_step.cstep;
    end
  end

  assign out_valid = vld_r;
  assign out_pipe  = res_r;

endmodule

// ----- hw/rtl/tabp_target.sv -----
// Cylinder targets from pipe pressure, speed and traction lever.
// Linear formulas are worked on the offset above full apply. Depends on tabp_pkg.
module tabp_target
  import tabp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  pipe_t in_pipe,
  output logic  out_valid,
  input  logic  out_ready,
  output tgt_t  out_tgt
);

  localparam logic [31:0] K333    = 32'd5586813;
  localparam logic [23:0] FRAC301 = 24'((64'd301 * 64'd16777216) / 64'd1000);
  localparam logic [23:0] FRAC801 = 24'((64'd801 * 64'd16777216) / 64'd1000);

  logic        vld_r;
  tgt_t        res_r;
  logic        load;
  logic [12:0] p;
  logic [12:0] dwide;
  logic [9:0]  d;
  logic [31:0] prod;
  logic [11:0] q0;
  logic [11:0] d4;
  logic [11:0] d2;
  logic [11:0] lin_lo;
  logic [11:0] lin_hi;
  logic        slow;
  logic        mid;
  logic        full_apply;
  logic        full_rel;
  logic [7:0]  lev_neg;
  logic [6:0]  mag;
  logic [11:0] tgt_trailer;
  logic [11:0] tgt_loco;
  logic [11:0] tgt_lever;

  assign in_ready = !vld_r || out_ready;
  assign load     = in_valid && in_ready;

  assign p     = in_pipe.pipe;
  assign dwide = p - FULL_APPLY_MBAR;
  assign d     = dwide[9:0];
  assign prod  = {22'd0, d} * K333;
  assign q0    = {4'd0, prod[31:24]};
  assign d4    = {d, 2'b00};
  assign d2    = {1'b0, d, 1'b0};

  assign lin_lo = CAP_LOW_MBAR - d4 - d2 - q0 - {11'd0, (prod[23:0] >= FRAC301)};
  assign lin_hi = CAP_HIGH_MBAR - d4 - q0 - {11'd0, (prod[23:0] >= FRAC801)};

  assign slow       = in_pipe.speed < LOW_SPEED_CMS;
  assign mid        = in_pipe.speed < HIGH_SPEED_CMS;
  assign full_apply = p <= FULL_APPLY_MBAR;
  assign full_rel   = p >= FULL_RELEASE_MBAR;

  assign lev_neg = 8'(-in_pipe.lever);

  always_comb begin
    if (in_pipe.lever < -8'sd100) begin
      mag = 7'd100;
    end else if (in_pipe.lever < 8'sd0) begin
      mag = lev_neg[6:0];
    end else begin
      mag = 7'd0;
    end
    tgt_lever = slow ? 12'({5'd0, mag} * LEVER_MBAR_PER_PCT) : 12'd0;

    priority if (full_rel) begin
      tgt_trailer = 12'd0;
    end else if (full_apply) begin
      tgt_trailer = mid ? CAP_LOW_MBAR : CAP_HIGH_MBAR;
    end else begin
      tgt_trailer = mid ? lin_lo : lin_hi;
    end

    priority if (!slow || full_rel) begin
      tgt_loco = 12'd0;
    end else if (full_apply) begin
      tgt_loco = CAP_LOW_MBAR;
    end else begin
      tgt_loco = lin_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r.cmd         <= in_pipe.cmd;
      res_r.pipe        <= in_pipe.pipe;
      res_r.cstep       <= in_pipe.cstep;
      res_r.tgt_trailer <= tgt_trailer;
      res_r.tgt_loco    <= tgt_loco;
      res_r.tgt_lever   <= tgt_lever;
    end
  end

  assign out_valid = vld_r;
  assign out_tgt   = res_r;

endmodule

// ----- hw/rtl/tabp_cyl.sv -----
// Cylinder slew with deadband for trailer and locomotive cylinders; holds the
// cylinder state and the result register. Depends on tabp_pkg.
module tabp_cyl
  import tabp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  tgt_t in_tgt,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  function automatic logic [11:0] slew(input logic [11:0] cur, input logic [11:0] tgt,
                                       input logic [13:0] step, input logic [9:0] db);
    logic        up;
    logic [11:0] gap;
    logic [11:0] res;
    up  = cur < tgt;
    gap = up ? (tgt - cur) : (cur - tgt);
    if (gap < {2'b00, db}) begin
      res = tgt;
    end else if ({2'b00, gap} > step) begin
      res = up ? (cur + step[11:0]) : (cur - step[11:0]);
    end else begin
      res = tgt;
    end
    return res;
  endfunction

  logic [11:0] trailer_r;
  logic [11:0] loco_r;
  logic [11:0] lever_cyl_r;
  logic [11:0] trailer_nxt;
  logic [11:0] loco_nxt;
  logic [11:0] lever_cyl_nxt;
  logic [11:0] shown_nxt;
  logic        use_loco;
  logic        vld_r;
  res_t        res_r;
  logic        load;

  assign in_ready = !vld_r || out_ready;
  assign load     = in_valid && in_ready;
  assign use_loco = in_tgt.tgt_loco >= in_tgt.tgt_lever;

  always_comb begin
    trailer_nxt   = slew(trailer_r, in_tgt.tgt_trailer, in_tgt.cstep, cfg.deadband);
    loco_nxt      = loco_r;
    lever_cyl_nxt = lever_cyl_r;
    if (use_loco) begin
      loco_nxt  = slew(loco_r, in_tgt.tgt_loco, in_tgt.cstep, cfg.deadband);
      shown_nxt = loco_nxt;
    end else begin
      lever_cyl_nxt = slew(lever_cyl_r, in_tgt.tgt_lever, in_tgt.cstep, cfg.deadband);
      shown_nxt     = lever_cyl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trailer_r   <= 12'd0;
      loco_r      <= 12'd0;
      lever_cyl_r <= 12'd0;
      vld_r       <= 1'b0;
    end else begin
      if (in_ready) vld_r <= in_valid;
      if (load) begin
        trailer_r   <= trailer_nxt;
        loco_r      <= loco_nxt;
        lever_cyl_r <= lever_cyl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r.cmd         <= in_tgt.cmd;
      res_r.pipe        <= in_tgt.pipe;
      res_r.trailer_cyl <= trailer_nxt;
      res_r.loco_cyl    <= loco_nxt;
      res_r.lever_cyl   <= lever_cyl_nxt;
      res_r.shown       <= shown_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

// ----- hw/rtl/train_air_brake_pressure_model.sv -----
// Train air brake pressure model. One tick request is taken per clock cycle
// while no stage stalls. The input register, rate multiply and divide by 1000
// form the pipe and cylinder steps; later stages update the brake command and
// pipe pressure, form the cylinder targets and slew the cylinders. The
// command/pipe update and the cylinder slew each close their state loop within
// their own stage, which allows one request per cycle. Each stage holds its
// request while the next one stalls. Configuration must be written through
// the APB-style port while the block is idle; the block does not enforce this.
// Depends on tabp_pkg, tabp_cfg, tabp_rate, tabp_pipe, tabp_target, tabp_cyl.
module train_air_brake_pressure_model
  import tabp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  input  logic              in_tvalid,
  output logic              in_tready,
  // elapsed_ms[9:0], speed_cms[23:10], traction_lever[31:24],
  // protection_mode[33:32], emergency_button[34], apply_lever[35],
  // release_lever[36], zero[39:37]
  input  logic [39:0]       in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // brake_command[2:0], pipe_mbar[15:3], trailer_cyl_mbar[27:16],
  // loco_cyl_mbar[39:28], loco_lever_cyl_mbar[51:40], shown_cyl_mbar[63:52]
  output logic [63:0]       out_tdata
);

  cfg_t  cfg;
  tick_t tick;
  step_t step;
  pipe_t pipe;
  tgt_t  tgt;
  res_t  res;
  logic  step_vld;
  logic  step_rdy;
  logic  pipe_vld;
  logic  pipe_rdy;
  logic  tgt_vld;
  logic  tgt_rdy;

  assign tick.ms    = in_tdata[9:0];
  assign tick.speed = in_tdata[23:10];
  assign tick.lever = in_tdata[31:24];
  assign tick.mode  = mode_t'(in_tdata[33:32]);
  assign tick.emerg = in_tdata[34];
  assign tick.apply = in_tdata[35];
  assign tick.rel   = in_tdata[36];

  tabp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  tabp_rate u_rate (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_tick   (tick),
    .out_valid (step_vld),
    .out_ready (step_rdy),
    .out_step  (step)
  );

  tabp_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (step_vld),
    .in_ready  (step_rdy),
    .in_step   (step),
    .out_valid (pipe_vld),
    .out_ready (pipe_rdy),
    .out_pipe  (pipe)
  );

  tabp_target u_target (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pipe_vld),
    .in_ready  (pipe_rdy),
    .in_pipe   (pipe),
    .out_valid (tgt_vld),
    .out_ready (tgt_rdy),
    .out_tgt   (tgt)
  );

  tabp_cyl u_cyl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (tgt_vld),
    .in_ready  (tgt_rdy),
    .in_tgt    (tgt),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {res.shown, res.lever_cyl, res.loco_cyl, res.trailer_cyl,
                      res.pipe, res.cmd};

endmodule
